>>> design/rgb_color_arithmetic_unit_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef RGB_COLOR_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RGB_COLOR_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication.
`define RCAU_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication.
`define RCAU_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

// Hold a stalled transaction.
`define RCAU_ASSERT_HOLD(lbl, clk, dis, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (dis) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("assertion failed: lbl");

`endif

>>> design/rcau_pkg.sv
package rcau_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned AMOUNT_W   = 11;
    localparam int unsigned STEP_W     = 9;
    localparam int unsigned LIN_W      = 10;
    localparam int unsigned SUM_W      = 24;
    localparam int unsigned PROD_W     = 48;
    localparam int unsigned RATIO_W    = 12;
    localparam int unsigned DIVIDEND_W = 17;
    localparam int unsigned DIVISOR_W  = 11;
    localparam int unsigned TRIAL_W    = DIVISOR_W + RATIO_W - 1;

    localparam int unsigned CH_MAX       = 255;
    localparam int unsigned BLEND_FULL   = 256;
    localparam int unsigned LUM_SCALE    = 1000;
    localparam int unsigned CH_SQ_MAX    = 255 * 255;
    localparam int unsigned W_RED        = 2126;
    localparam int unsigned W_GREEN      = 7152;
    localparam int unsigned W_BLUE       = 722;
    localparam int unsigned W_SUM        = 10000;
    localparam int unsigned RATIO_OFFSET = 50;
    localparam int unsigned RATIO_SCALE  = 100;

    // divide by W_SUM: multiply by rounded-up reciprocal, exact below 2**24
    localparam int unsigned LUMA_SHIFT = 37;
    localparam logic [SUM_W-1:0] LUMA_RECIP =
        SUM_W'((64'd1 << LUMA_SHIFT) / W_SUM + 64'd1);

    // divider: one quotient bit per step, DIV_BPS steps per stage
    localparam int unsigned DIV_BPS    = 3;
    localparam int unsigned DIV_STAGES = RATIO_W / DIV_BPS;
    localparam int unsigned NUM_STAGES = 3 + DIV_STAGES;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_LIGHTEN  = 2'd0,
        OP_DARKEN   = 2'd1,
        OP_BLEND    = 2'd2,
        OP_CONTRAST = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [STEP_W-1:0]  step;
    } item_t;

    typedef logic [LIN_W-1:0] lin_tab_t [256];

    function automatic lin_tab_t build_lin_tab();
        lin_tab_t tab;
        for (int unsigned i = 0; i < 256; i++) begin
            tab[i] = LIN_W'((i * i * LUM_SCALE) / CH_SQ_MAX);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

>>> design/rcau_queue.sv
module rcau_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rcau_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rcau_pkg::item_t pop_item
);

    logic [rcau_pkg::QCNT_W-1:0] cnt_reg;
    logic [rcau_pkg::QCNT_W-1:0] cnt_next;
    logic [rcau_pkg::QCNT_W-1:0] cnt_left;
    rcau_pkg::item_t             head_reg;
    rcau_pkg::item_t             tail_reg;
    logic                        push;
    logic                        pop;

    assign push_ready = (cnt_reg != rcau_pkg::QCNT_W'(rcau_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = head_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign cnt_left   = cnt_reg - rcau_pkg::QCNT_W'(pop);
    assign cnt_next   = cnt_left + rcau_pkg::QCNT_W'(push);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (cnt_reg == rcau_pkg::QCNT_W'(rcau_pkg::QUEUE_DEPTH))) begin
            head_reg <= tail_reg;
        end
        if (push) begin
            if (cnt_left == '0) begin
                head_reg <= push_item;
            end else begin
                tail_reg <= push_item;
            end
        end
    end

endmodule

>>> design/rcau_front.sv
module rcau_front (
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [rcau_pkg::COLOR_W-1:0]        s_color_a,
    input  logic [rcau_pkg::COLOR_W-1:0]        s_color_b,
    input  logic signed [rcau_pkg::AMOUNT_W-1:0] s_amount,
    output logic                                q_valid,
    input  logic                                q_ready,
    output rcau_pkg::item_t                     q_item
);

    rcau_pkg::op_t               op;
    logic [rcau_pkg::STEP_W-1:0] step;

    assign op = rcau_pkg::op_t'(s_action);

    // clamp the amount to the range of the operation
    always_comb begin
        step = '0;
        case (op)
            rcau_pkg::OP_LIGHTEN, rcau_pkg::OP_DARKEN: begin
                if (s_amount < 0) begin
                    step = '0;
                end else if (s_amount > rcau_pkg::AMOUNT_W'(rcau_pkg::CH_MAX)) begin
                    step = rcau_pkg::STEP_W'(rcau_pkg::CH_MAX);
                end else begin
                    step = s_amount[rcau_pkg::STEP_W-1:0];
                end
            end
            rcau_pkg::OP_BLEND: begin
                if (s_amount < 0) begin
                    step = '0;
                end else if (s_amount > rcau_pkg::AMOUNT_W'(rcau_pkg::BLEND_FULL)) begin
                    step = rcau_pkg::STEP_W'(rcau_pkg::BLEND_FULL);
                end else begin
                    step = s_amount[rcau_pkg::STEP_W-1:0];
                end
            end
            default: begin
                step = '0;
            end
        endcase
    end

    assign s_ready         = q_ready;
    assign q_valid         = s_valid;
    assign q_item.op       = op;
    assign q_item.color_a  = s_color_a;
    assign q_item.color_b  = s_color_b;
    assign q_item.step     = step;

endmodule

>>> design/rcau_back.sv
module rcau_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  rcau_pkg::item_t                q_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rcau_pkg::COLOR_W-1:0]   m_color_out,
    output logic [rcau_pkg::RATIO_W-1:0]   m_contrast_ratio
);

    localparam int unsigned LAST = rcau_pkg::NUM_STAGES - 1;

    logic                              en;
    logic [rcau_pkg::NUM_STAGES-1:0]   vld_reg;
    logic [rcau_pkg::COLOR_W-1:0]      color_reg [rcau_pkg::NUM_STAGES];
    logic                              ctr_reg   [rcau_pkg::NUM_STAGES];

    logic [rcau_pkg::COLOR_W-1:0]      color_next;
    logic [rcau_pkg::SUM_W-1:0]        suma_next;
    logic [rcau_pkg::SUM_W-1:0]        sumb_next;
    logic [rcau_pkg::SUM_W-1:0]        suma_reg;
    logic [rcau_pkg::SUM_W-1:0]        sumb_reg;
    logic [rcau_pkg::PROD_W-1:0]       proda;
    logic [rcau_pkg::PROD_W-1:0]       prodb;
    logic [rcau_pkg::LIN_W-1:0]        luma_a_reg;
    logic [rcau_pkg::LIN_W-1:0]        luma_b_reg;
    logic [rcau_pkg::LIN_W-1:0]        hi;
    logic [rcau_pkg::LIN_W-1:0]        lo;

    logic [rcau_pkg::DIVIDEND_W-1:0]   rem_reg [rcau_pkg::DIV_STAGES];
    logic [rcau_pkg::DIVISOR_W-1:0]    div_reg [rcau_pkg::DIV_STAGES];
    logic [rcau_pkg::RATIO_W-1:0]      quo_reg [rcau_pkg::DIV_STAGES+1];

    function automatic logic [rcau_pkg::SUM_W-1:0] luma_sum(
        input logic [rcau_pkg::COLOR_W-1:0] c
    );
        logic [rcau_pkg::SUM_W-1:0] lr;
        logic [rcau_pkg::SUM_W-1:0] lg;
        logic [rcau_pkg::SUM_W-1:0] lb;
        lr = rcau_pkg::SUM_W'(rcau_pkg::LIN_TAB[c[23:16]]);
        lg = rcau_pkg::SUM_W'(rcau_pkg::LIN_TAB[c[15:8]]);
        lb = rcau_pkg::SUM_W'(rcau_pkg::LIN_TAB[c[7:0]]);
        return lr * rcau_pkg::SUM_W'(rcau_pkg::W_RED)
             + lg * rcau_pkg::SUM_W'(rcau_pkg::W_GREEN)
             + lb * rcau_pkg::SUM_W'(rcau_pkg::W_BLUE);
    endfunction

    // advance the whole pipe unless the result register is held
    assign en      = !vld_reg[LAST] || m_ready;
    assign q_ready = en;

    // per-channel step and blend
    always_comb begin
        logic [rcau_pkg::CH_W-1:0] ca;
        logic [rcau_pkg::CH_W-1:0] cb;
        logic [rcau_pkg::STEP_W-1:0] up;
        logic [16:0] mix;
        color_next = '0;
        for (int ch = 0; ch < 3; ch++) begin
            ca  = q_item.color_a[ch*8 +: 8];
            cb  = q_item.color_b[ch*8 +: 8];
            up  = rcau_pkg::STEP_W'(ca) + q_item.step;
            mix = 17'(ca) * 17'(rcau_pkg::STEP_W'(rcau_pkg::BLEND_FULL) - q_item.step)
                + 17'(cb) * 17'(q_item.step);
            case (q_item.op)
                rcau_pkg::OP_LIGHTEN: begin
                    color_next[ch*8 +: 8] =
                        (up > rcau_pkg::STEP_W'(rcau_pkg::CH_MAX)) ? 8'hFF : up[7:0];
                end
                rcau_pkg::OP_DARKEN: begin
                    color_next[ch*8 +: 8] =
                        (rcau_pkg::STEP_W'(ca) < q_item.step) ? 8'h00 : ca - q_item.step[7:0];
                end
                rcau_pkg::OP_BLEND: begin
                    color_next[ch*8 +: 8] = mix[15:8];
                end
                default: begin
                    color_next[ch*8 +: 8] = 8'h00;
                end
            endcase
        end
    end

    assign suma_next = luma_sum(q_item.color_a);
    assign sumb_next = luma_sum(q_item.color_b);
    assign proda     = rcau_pkg::PROD_W'(suma_reg) * rcau_pkg::PROD_W'(rcau_pkg::LUMA_RECIP);
    assign prodb     = rcau_pkg::PROD_W'(sumb_reg) * rcau_pkg::PROD_W'(rcau_pkg::LUMA_RECIP);
    assign hi        = (luma_a_reg > luma_b_reg) ? luma_a_reg : luma_b_reg;
    assign lo        = (luma_a_reg > luma_b_reg) ? luma_b_reg : luma_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[rcau_pkg::NUM_STAGES-2:0], q_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            color_reg[0] <= color_next;
            ctr_reg[0]   <= (q_item.op == rcau_pkg::OP_CONTRAST);
            for (int i = 1; i < rcau_pkg::NUM_STAGES; i++) begin
                color_reg[i] <= color_reg[i-1];
                ctr_reg[i]   <= ctr_reg[i-1];
            end
            suma_reg   <= suma_next;
            sumb_reg   <= sumb_next;
            luma_a_reg <= proda[rcau_pkg::LUMA_SHIFT +: rcau_pkg::LIN_W];
            luma_b_reg <= prodb[rcau_pkg::LUMA_SHIFT +: rcau_pkg::LIN_W];
            rem_reg[0] <= rcau_pkg::DIVIDEND_W'(
                (rcau_pkg::DIVIDEND_W'(hi) + rcau_pkg::DIVIDEND_W'(rcau_pkg::RATIO_OFFSET))
                * rcau_pkg::DIVIDEND_W'(rcau_pkg::RATIO_SCALE));
            div_reg[0] <= rcau_pkg::DIVISOR_W'(lo) + rcau_pkg::DIVISOR_W'(rcau_pkg::RATIO_OFFSET);
            quo_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < rcau_pkg::DIV_STAGES; s++) begin : g_div
        logic [rcau_pkg::DIVIDEND_W-1:0] rem_next;
        logic [rcau_pkg::RATIO_W-1:0]    quo_next;

        always_comb begin
            logic [rcau_pkg::TRIAL_W-1:0] trial;
            rem_next = rem_reg[s];
            quo_next = quo_reg[s];
            for (int k = 0; k < rcau_pkg::DIV_BPS; k++) begin
                trial = rcau_pkg::TRIAL_W'(div_reg[s])
                    << (rcau_pkg::RATIO_W - 1 - s * rcau_pkg::DIV_BPS - k);
                if (rcau_pkg::TRIAL_W'(rem_next) >= trial) begin
                    rem_next = rem_next - rcau_pkg::DIVIDEND_W'(trial);
                    quo_next[rcau_pkg::RATIO_W - 1 - s * rcau_pkg::DIV_BPS - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[s+1] <= quo_next;
            end
        end

        if (s < rcau_pkg::DIV_STAGES - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= rem_next;
                    div_reg[s+1] <= div_reg[s];
                end
            end
        end
    end

    assign m_valid          = vld_reg[LAST];
    assign m_color_out      = color_reg[LAST];
    assign m_contrast_ratio = ctr_reg[LAST] ? quo_reg[rcau_pkg::DIV_STAGES] : '0;

endmodule

>>> design/rgb_color_arithmetic_unit_core.sv
// RGB888 colour unit: lighten, darken, blend and contrast ratio, one result per
// transaction. A transaction enters a two-entry queue and then a seven-stage
// pipeline (channel arithmetic and luminance sums, reciprocal multiply, ratio
// set-up, four stages of a pipelined divider giving three quotient bits each),
// and one transaction per cycle is sustained while m_ready stays high. A result
// held by a low m_ready freezes the pipeline, and s_ready then stays up until
// the queue holds two transactions.
module rgb_color_arithmetic_unit_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_action,
    input  logic [rcau_pkg::COLOR_W-1:0]         s_color_a,
    input  logic [rcau_pkg::COLOR_W-1:0]         s_color_b,
    input  logic signed [rcau_pkg::AMOUNT_W-1:0] s_amount,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rcau_pkg::COLOR_W-1:0]         m_color_out,
    output logic [rcau_pkg::RATIO_W-1:0]         m_contrast_ratio
);

    logic            fq_valid;
    logic            fq_ready;
    rcau_pkg::item_t fq_item;
    logic            qb_valid;
    logic            qb_ready;
    rcau_pkg::item_t qb_item;

    rcau_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_color_a (s_color_a),
        .s_color_b (s_color_b),
        .s_amount  (s_amount),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    rcau_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    rcau_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (qb_valid),
        .q_ready          (qb_ready),
        .q_item           (qb_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_color_out      (m_color_out),
        .m_contrast_ratio (m_contrast_ratio)
    );

endmodule

>>> design/rcau_checker.sv
`include "rgb_color_arithmetic_unit_core_assert.svh"

module rcau_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [1:0]                           s_action,
    input logic [rcau_pkg::COLOR_W-1:0]         s_color_a,
    input logic [rcau_pkg::COLOR_W-1:0]         s_color_b,
    input logic signed [rcau_pkg::AMOUNT_W-1:0] s_amount,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [rcau_pkg::COLOR_W-1:0]         m_color_out,
    input logic [rcau_pkg::RATIO_W-1:0]         m_contrast_ratio
);

    logic [1+2*rcau_pkg::COLOR_W+rcau_pkg::AMOUNT_W:0] s_payload;
    logic [rcau_pkg::COLOR_W+rcau_pkg::RATIO_W-1:0]    m_payload;
    logic                                              color_set;
    logic                                              ratio_set;
    logic                                              ratio_in_range;

    assign s_payload      = {s_action, s_color_a, s_color_b, s_amount};
    assign m_payload      = {m_color_out, m_contrast_ratio};
    assign color_set      = (m_color_out != '0);
    assign ratio_set      = (m_contrast_ratio != '0);
    assign ratio_in_range = (m_contrast_ratio >= 12'd100) && (m_contrast_ratio <= 12'd2100);

    `RCAU_ASSERT_HOLD(a_s_hold, aclk, !aresetn, s_valid, s_ready, s_payload)
    `RCAU_ASSERT_HOLD(a_m_hold, aclk, !aresetn, m_valid, m_ready, m_payload)
    `RCAU_ASSERT_IMPL(a_one_field, aclk, !aresetn, m_valid, !color_set || !ratio_set)
    `RCAU_ASSERT_IMPL(a_ratio_range, aclk, !aresetn, m_valid && ratio_set, ratio_in_range)
    `RCAU_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid)

endmodule

bind rgb_color_arithmetic_unit_core rcau_checker u_rcau_checker (.*);
